@@ hw/rtl/krls_pkg.sv @@
// Shared types and constants for the keyed record log store.
// Holds the request, response and configuration structs and the code values.
// No dependencies.
package krls_pkg;

   localparam int FP_W      = 13;   // byte position / fill point width
   localparam int HELD_W    = 11;   // records_held field width
   localparam int CSR_AW    = 5;    // byte address width of the register port
   localparam int CSR_DW    = 32;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FIND  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_MISS    = 2'd2;

   localparam logic [1:0] POL_REFUSE        = 2'd0;
   localparam logic [1:0] POL_CLEAR_ON_FULL = 2'd1;
   localparam logic [1:0] POL_CLEAR_ALWAYS  = 2'd2;

   localparam logic [2:0] REG_KEY_BYTES    = 3'd0;
   localparam logic [2:0] REG_LENGTH_BYTES = 3'd1;
   localparam logic [2:0] REG_AREA_BYTES   = 3'd2;
   localparam logic [2:0] REG_POLICY       = 3'd3;
   localparam logic [2:0] REG_RECORDING    = 3'd4;
   localparam logic [2:0] REG_LOOKUP       = 3'd5;

   localparam logic [31:0] LEN1_MAX = 32'h0000_00FF;
   localparam logic [31:0] LEN2_MAX = 32'h0000_FFFF;
   localparam logic [31:0] LEN3_MAX = 32'h00FF_FFFF;

   typedef struct packed {
      logic        func;
      logic [12:0] request_bytes;
      logic [63:0] search_key;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] record_offset;
      logic [10:0] records_held;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  key_bytes;
      logic [2:0]  length_field_bytes;
      logic [12:0] area_bytes;
      logic [1:0]  overflow_policy;
      logic        recording;
      logic        lookup_enabled;
   } cfg_type;

endpackage

@@ hw/rtl/keyed_record_log_store.sv @@
// Top level of the keyed record log store: request sequencer, record memory
// and result register. Depends on krls_pkg, krls_ram and krls_csr.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_valid / req_stall   req_type (func, request_bytes, search_key)
//   rsp_*     out        rsp_valid / rsp_stall   rsp_type (status, record_offset, records_held)
//   csr_*     in/out     APB setup + access      32-bit registers at byte address 4*index
//
// One request is worked at a time; req_stall is high from acceptance until the
// result is loaded into the output register. An allocation passes a length check
// and a fit check and then writes its header words (up to 4), unless a check refuses it.
// A find checks each record's header, reads W words (0 to 3) through the single memory
// read port for the key and length field, and compares the key; it ends at a match,
// at a header check that misses, or when the walk runs past the position range.
// Reset clears the fill point and record count; the memory is not cleared.
// A stalled result holds in the output register while the next request is taken.
module keyed_record_log_store
   import krls_pkg::*;
#(
   parameter int AREA_BYTES    = 4096,
   parameter int MAX_KEY_BYTES = 8,
   parameter int MAX_RECORDS   = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int WORDS = AREA_BYTES / 4;
   localparam int WA_W  = $clog2(WORDS);
   localparam int TOT_W = $clog2(MAX_RECORDS + 1);
   localparam logic [16:0]      AREA_LIM = 17'(AREA_BYTES);
   localparam logic [TOT_W-1:0] TOT_MAX  = TOT_W'(MAX_RECORDS);
   localparam logic [3:0]       KEY_LIM  = 4'(MAX_KEY_BYTES);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ACHECK = 4'd1;
   localparam logic [3:0] ST_AFIT   = 4'd2;
   localparam logic [3:0] ST_AWRITE = 4'd3;
   localparam logic [3:0] ST_FCHECK = 4'd4;
   localparam logic [3:0] ST_FREAD  = 4'd5;
   localparam logic [3:0] ST_FCAPT  = 4'd6;
   localparam logic [3:0] ST_FEVAL  = 4'd7;
   localparam logic [3:0] ST_RESP   = 4'd8;

   cfg_type cfg;

   krls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Registers and their next values.
   logic [3:0]       state_ff, state_in;
   logic [12:0]      reqb_ff, reqb_in;
   logic [63:0]      key_ff, key_in;
   logic [13:0]      alen_ff, alen_in;
   logic [FP_W-1:0]  fill_ff, fill_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [FP_W-1:0]  pos_ff, pos_in;
   logic [TOT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       k_ff, k_in;
   logic [31:0]      buf_ff [3];
   logic [31:0]      buf_in [3];
   logic [1:0]       st_ff, st_in;
   logic [11:0]      off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Memory port.
   logic            ram_we, ram_re;
   logic [WA_W-1:0] ram_waddr, ram_raddr;
   logic [31:0]     ram_wdata, ram_rdata;

   krls_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Effective configuration and derived sizes.
   logic [3:0]  kb;
   logic [2:0]  lb;
   logic [2:0]  rd;
   logic [4:0]  hl;
   logic [12:0] ea;
   logic [12:0] room;
   logic [1:0]  nrd;
   logic [2:0]  nwr;

   assign kb   = (cfg.key_bytes > KEY_LIM) ? KEY_LIM : cfg.key_bytes;
   assign lb   = cfg.length_field_bytes;
   assign rd   = (lb > 3'd4) ? 3'd4 : lb;
   assign hl   = 5'(kb) + 5'(lb);
   assign ea   = ({4'b0, cfg.area_bytes} > AREA_LIM) ? AREA_LIM[12:0] : cfg.area_bytes;
   assign room = (fill_ff > ea) ? 13'd0 : ea - fill_ff;
   assign nrd  = 2'((5'(kb) + 5'(rd) + 5'd3) >> 2);
   assign nwr  = 3'((hl + 5'd3) >> 2);

   // Allocation checks.
   logic [12:0] dl;
   logic [31:0] dl32;
   logic [13:0] alen_c;
   logic        len_bad;
   logic        alloc_bad;
   logic        clear_now;

   assign dl     = reqb_ff - 13'(hl);
   assign dl32   = 32'(dl);
   assign alen_c = ({1'b0, reqb_ff} + 14'd3) & ~14'd3;

   always_comb begin
      case (lb)
         3'd0:    len_bad = (dl != 13'd0);
         3'd1:    len_bad = (dl32 > LEN1_MAX);
         3'd2:    len_bad = (dl32 > LEN2_MAX);
         3'd3:    len_bad = (dl32 > LEN3_MAX);
         default: len_bad = 1'b0;
      endcase
   end

   assign alloc_bad = !cfg.recording || (reqb_ff < 13'(hl)) || (reqb_ff > ea) || len_bad;
   assign clear_now = ((cfg.overflow_policy == POL_CLEAR_ON_FULL) && (alen_c > {1'b0, room}))
                      || (cfg.overflow_policy == POL_CLEAR_ALWAYS);

   // Header word k of the record being allocated: key bytes, then the length
   // field, whose bytes above the fourth are zero.
   logic [31:0] hdr_word;

   always_comb begin
      logic [3:0] h;
      logic [3:0] li;
      hdr_word = '0;
      for (int j = 0; j < 4; j++) begin
         h  = {k_ff, 2'b00} + 4'(j);
         li = h - kb;
         if (h < kb) begin
            hdr_word[8*j +: 8] = key_ff[{h[2:0], 3'b000} +: 8];
         end else if (5'(h) < hl && li < 4'd4) begin
            hdr_word[8*j +: 8] = dl32[{li[1:0], 3'b000} +: 8];
         end
      end
   end

   // Find evaluation over the captured header words.
   logic [95:0] hdr;
   logic        key_hit;
   logic [31:0] rec_len;
   logic [33:0] next_pos;
   logic        pos_ovf;

   assign hdr = {buf_ff[2], buf_ff[1], buf_ff[0]};

   always_comb begin
      logic [3:0] idx;
      key_hit = 1'b1;
      rec_len = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < kb && hdr[8*i +: 8] != key_ff[8*i +: 8]) begin
            key_hit = 1'b0;
         end
      end
      for (int i = 0; i < 4; i++) begin
         idx = kb + 4'(i);
         if (3'(i) < rd) begin
            rec_len[8*i +: 8] = hdr[{idx, 3'b000} +: 8];
         end
      end
   end

   // The walk steps by the aligned size of the whole record.
   assign next_pos = (34'(pos_ff) + 34'(hl) + 34'(rec_len) + 34'd3) & ~34'd3;
   assign pos_ovf  = |next_pos[33:FP_W];

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      reqb_in      = reqb_ff;
      key_in       = key_ff;
      alen_in      = alen_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      buf_in       = buf_ff;
      st_in        = st_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = WA_W'((fill_ff >> 2) + FP_W'(k_ff));
      ram_raddr    = WA_W'((pos_ff >> 2) + FP_W'(k_ff));
      ram_wdata    = hdr_word;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               reqb_in  = req_payload.request_bytes;
               key_in   = req_payload.search_key;
               pos_in   = '0;
               cnt_in   = '0;
               k_in     = '0;
               state_in = (req_payload.func == FUNC_FIND) ? ST_FCHECK : ST_ACHECK;
            end
         end
         ST_ACHECK: begin
            if (alloc_bad) begin
               st_in    = STATUS_REFUSED;
               off_in   = '0;
               state_in = ST_RESP;
            end else begin
               // A policy clear stays in effect even if the record is refused.
               alen_in = alen_c;
               if (clear_now) begin
                  fill_in  = '0;
                  total_in = '0;
               end
               state_in = ST_AFIT;
            end
         end
         ST_AFIT: begin
            if (alen_ff > {1'b0, room} || total_ff >= TOT_MAX) begin
               st_in    = STATUS_REFUSED;
               off_in   = '0;
               state_in = ST_RESP;
            end else begin
               st_in  = STATUS_OK;
               off_in = fill_ff[11:0];
               k_in   = '0;
               if (nwr == 3'd0) begin
                  fill_in  = FP_W'({1'b0, fill_ff} + alen_ff);
                  total_in = total_ff + 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_AWRITE;
               end
            end
         end
         ST_AWRITE: begin
            ram_we = 1'b1;
            k_in   = k_ff + 2'd1;
            if (3'(k_ff) == nwr - 3'd1) begin
               fill_in  = FP_W'({1'b0, fill_ff} + alen_ff);
               total_in = total_ff + 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_FCHECK: begin
            k_in = '0;
            if (!cfg.lookup_enabled || cnt_ff >= total_ff
                || ({1'b0, pos_ff} + 14'(hl)) > {1'b0, fill_ff}) begin
               st_in    = STATUS_MISS;
               off_in   = '0;
               state_in = ST_RESP;
            end else begin
               state_in = (nrd == 2'd0) ? ST_FEVAL : ST_FREAD;
            end
         end
         ST_FREAD: begin
            ram_re   = 1'b1;
            state_in = ST_FCAPT;
         end
         ST_FCAPT: begin
            buf_in[k_ff] = ram_rdata;
            k_in         = k_ff + 2'd1;
            state_in     = (k_ff == nrd - 2'd1) ? ST_FEVAL : ST_FREAD;
         end
         ST_FEVAL: begin
            if (key_hit) begin
               st_in    = STATUS_OK;
               off_in   = pos_ff[11:0];
               state_in = ST_RESP;
            end else if (pos_ovf) begin
               // Past any fill point: the next header check would miss.
               st_in    = STATUS_MISS;
               off_in   = '0;
               state_in = ST_RESP;
            end else begin
               pos_in   = next_pos[FP_W-1:0];
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_FCHECK;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = st_ff;
               rsp_in.record_offset = off_ff;
               rsp_in.records_held  = HELD_W'(total_ff);
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reqb_ff <= reqb_in;
      key_ff  <= key_in;
      alen_ff <= alen_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      buf_ff  <= buf_in;
      st_ff   <= st_in;
      off_ff  <= off_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The sequencer leaves idle only when a request is taken.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle without a request");

   // Fill point and record count change only while an allocation is worked.
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FCHECK || state_ff == ST_FEVAL)
      |=> ($stable(fill_ff) && $stable(total_ff)))
      else $error("store state changed outside an allocation");

   // Records are word aligned and never pass the end of the area.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[1:0] == 2'b00) && (17'(fill_ff) <= AREA_LIM))
      else $error("fill point misaligned or past the area");

   // The memory is written only by the header write state.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_AWRITE && !ram_re))
      else $error("memory written outside the header write");

endmodule

@@ hw/rtl/krls_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module krls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/krls_csr.sv @@
// Configuration register file behind an APB-style port.
// Depends on krls_pkg for the configuration struct and register indexes.
module krls_csr
   import krls_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       write;

   assign index = csr_paddr[CSR_AW-1:2];
   assign write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_KEY_BYTES:    cfg_in.key_bytes          = csr_pwdata[3:0];
            REG_LENGTH_BYTES: cfg_in.length_field_bytes = csr_pwdata[2:0];
            REG_AREA_BYTES:   cfg_in.area_bytes         = csr_pwdata[12:0];
            REG_POLICY:       cfg_in.overflow_policy    = csr_pwdata[1:0];
            REG_RECORDING:    cfg_in.recording          = csr_pwdata[0];
            REG_LOOKUP:       cfg_in.lookup_enabled     = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes          <= 4'd4;
         cfg_ff.length_field_bytes <= 3'd4;
         cfg_ff.area_bytes         <= 13'd4096;
         cfg_ff.overflow_policy    <= POL_REFUSE;
         cfg_ff.recording          <= 1'b1;
         cfg_ff.lookup_enabled     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_KEY_BYTES:    csr_prdata = CSR_DW'(cfg_ff.key_bytes);
         REG_LENGTH_BYTES: csr_prdata = CSR_DW'(cfg_ff.length_field_bytes);
         REG_AREA_BYTES:   csr_prdata = CSR_DW'(cfg_ff.area_bytes);
         REG_POLICY:       csr_prdata = CSR_DW'(cfg_ff.overflow_policy);
         REG_RECORDING:    csr_prdata = CSR_DW'(cfg_ff.recording);
         REG_LOOKUP:       csr_prdata = CSR_DW'(cfg_ff.lookup_enabled);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule
